@@ rtl/xxh32_pkg.sv @@
package xxh32_pkg;

  localparam logic [31:0] XP1 = 32'h9E37_79B1;
  localparam logic [31:0] XP2 = 32'h85EB_CA77;
  localparam logic [31:0] XP3 = 32'hC2B2_AE3D;
  localparam logic [31:0] XP4 = 32'h27D4_EB2F;
  localparam logic [31:0] XP5 = 32'h1656_67B1;

  // Stripe is 16 bytes; four extra bytes hold what spills past a stripe end.
  localparam int unsigned BUF_BYTES = 20;
  localparam int unsigned FILL_W    = 5;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_F_MUL,
    OP_F_ROT,
    OP_F_UPD,
    OP_C_INIT,
    OP_C_ADD,
    OP_W_MUL,
    OP_W_ROT,
    OP_W_UPD,
    OP_B_MUL,
    OP_B_ROT,
    OP_B_UPD,
    OP_A1,
    OP_A2,
    OP_A3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] k;    // lane step index for fold and converge
  } cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              seen;
  } status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
    return (x << r) | (x >> (6'd32 - {1'b0, r}));
  endfunction

endpackage

@@ rtl/xxhash32_stream_core.sv @@
// Streaming XXH32 hash engine. Message bytes arrive as little-endian words on
// the in_ stream, each with a count of valid low bytes (0 to 4, larger counts
// act as 4); in_tlast marks the final item of a message, and one hash item
// leaves on the out_ stream per message, after which the engine starts the
// next message from the current seed. The seed is written through the cfg_
// channel, which is always ready; write it only while the engine is idle. A
// write before the first stripe of a message is folded applies to that
// message, a later write applies from the next message. One item is in work
// at a time, driven by a controller that steps a single shared 32x32
// multiplier: each item is loaded and checked; one that completes a 16-byte
// stripe then gets a multiply, rotate and update for each of the four lanes.
// The last item then starts the converge, adds the lanes if any stripe was
// folded, takes each leftover word, then each leftover byte, through the same
// steps, and ends the avalanche once the previous hash is taken. The output
// register lets the next message be accepted while a hash waits on out_tready.
module xxhash32_stream_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] data_word, [34:32] valid_bytes, rest zero
  input  logic        in_tlast,   // last item of the message
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] hash
  // Seed write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  xxh32_pkg::cmd_t    cmd;
  xxh32_pkg::status_t status;

  // Seed writes are taken at once
  assign cfg_ready = 1'b1;

  xxh32_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  xxh32_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_word   (in_tdata[31:0]),
    .valid_bytes (in_tdata[34:32]),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .status      (status),
    .hash        (out_tdata)
  );

endmodule

@@ rtl/xxh32_dp.sv @@
module xxh32_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  xxh32_pkg::cmd_t       cmd,
  input  logic [31:0]           data_word,
  input  logic [2:0]            valid_bytes,
  input  logic                  cfg_valid,
  input  logic [31:0]           cfg_data,
  output xxh32_pkg::status_t    status,
  output logic [31:0]           hash
);

  localparam int unsigned BUF_W = 8 * xxh32_pkg::BUF_BYTES;

  logic [31:0]                    seed_r, seed_nxt;
  logic [31:0]                    lane_r [4];
  logic [31:0]                    lane_nxt [4];
  logic [xxh32_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic [31:0]                    len_r, len_nxt;
  logic                           seen_r, seen_nxt;
  logic [BUF_W-1:0]               buf_r, buf_nxt;
  logic [31:0]                    p_r, p_nxt;
  logic [31:0]                    t_r, t_nxt;
  logic [31:0]                    h_r, h_nxt;
  logic [31:0]                    hash_r, hash_nxt;

  logic [2:0]                     n_bytes;
  logic [31:0]                    mul_a, mul_b;
  logic [31:0]                    mul_lo;
  logic [4:0]                     conv_rot;

  assign n_bytes  = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
  // Only the low word of the product is ever used
  assign mul_lo   = mul_a * mul_b;

  always_comb begin
    unique case (cmd.k)
      2'd0: conv_rot = 5'd1;
      2'd1: conv_rot = 5'd7;
      2'd2: conv_rot = 5'd12;
      default: conv_rot = 5'd18;
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = t_r;
    mul_b = xxh32_pkg::XP1;
    unique case (cmd.op)
      xxh32_pkg::OP_F_MUL: begin
        mul_a = buf_r[31:0];
        mul_b = xxh32_pkg::XP2;
      end
      xxh32_pkg::OP_W_MUL: begin
        mul_a = buf_r[31:0];
        mul_b = xxh32_pkg::XP3;
      end
      xxh32_pkg::OP_W_UPD: begin
        mul_a = t_r;
        mul_b = xxh32_pkg::XP4;
      end
      xxh32_pkg::OP_B_MUL: begin
        mul_a = {24'd0, buf_r[7:0]};
        mul_b = xxh32_pkg::XP5;
      end
      xxh32_pkg::OP_A1: begin
        mul_a = h_r ^ (h_r >> 15);
        mul_b = xxh32_pkg::XP2;
      end
      xxh32_pkg::OP_A2: begin
        mul_a = h_r ^ (h_r >> 13);
        mul_b = xxh32_pkg::XP3;
      end
      default: begin
        mul_a = t_r;
        mul_b = xxh32_pkg::XP1;
      end
    endcase
  end

  always_comb begin
    seed_nxt = seed_r;
    fill_nxt = fill_r;
    len_nxt  = len_r;
    seen_nxt = seen_r;
    buf_nxt  = buf_r;
    p_nxt    = p_r;
    t_nxt    = t_r;
    h_nxt    = h_r;
    hash_nxt = hash_r;
    for (int i = 0; i < 4; i++) begin
      lane_nxt[i] = lane_r[i];
    end

    unique case (cmd.op)
      xxh32_pkg::OP_LOAD: begin
        for (int p = 0; p < xxh32_pkg::BUF_BYTES; p++) begin
          for (int j = 0; j < 4; j++) begin
            if ((3'(j) < n_bytes) && ((fill_r + xxh32_pkg::FILL_W'(j))
                == xxh32_pkg::FILL_W'(p))) begin
              buf_nxt[p*8 +: 8] = data_word[j*8 +: 8];
            end
          end
        end
        fill_nxt = fill_r + {2'd0, n_bytes};
        len_nxt  = len_r + {29'd0, n_bytes};
      end
      xxh32_pkg::OP_F_MUL, xxh32_pkg::OP_W_MUL, xxh32_pkg::OP_B_MUL: begin
        p_nxt = mul_lo;
      end
      xxh32_pkg::OP_F_ROT: begin
        t_nxt = xxh32_pkg::rotl32(lane_r[0] + p_r, 5'd13);
      end
      xxh32_pkg::OP_F_UPD: begin
        lane_nxt[0] = lane_r[1];
        lane_nxt[1] = lane_r[2];
        lane_nxt[2] = lane_r[3];
        lane_nxt[3] = mul_lo;
        buf_nxt     = buf_r >> 32;
        if (cmd.k == 2'd3) begin
          fill_nxt = fill_r - xxh32_pkg::FILL_W'(16);
          seen_nxt = 1'b1;
        end
      end
      xxh32_pkg::OP_C_INIT: begin
        h_nxt = seen_r ? len_r : (len_r + seed_r + xxh32_pkg::XP5);
      end
      xxh32_pkg::OP_C_ADD: begin
        h_nxt       = h_r + xxh32_pkg::rotl32(lane_r[0], conv_rot);
        lane_nxt[0] = lane_r[1];
        lane_nxt[1] = lane_r[2];
        lane_nxt[2] = lane_r[3];
        lane_nxt[3] = lane_r[0];
      end
      xxh32_pkg::OP_W_ROT: begin
        t_nxt = xxh32_pkg::rotl32(h_r + p_r, 5'd17);
      end
      xxh32_pkg::OP_W_UPD: begin
        h_nxt    = mul_lo;
        buf_nxt  = buf_r >> 32;
        fill_nxt = fill_r - xxh32_pkg::FILL_W'(4);
      end
      xxh32_pkg::OP_B_ROT: begin
        t_nxt = xxh32_pkg::rotl32(h_r + p_r, 5'd11);
      end
      xxh32_pkg::OP_B_UPD: begin
        h_nxt    = mul_lo;
        buf_nxt  = buf_r >> 8;
        fill_nxt = fill_r - xxh32_pkg::FILL_W'(1);
      end
      xxh32_pkg::OP_A1, xxh32_pkg::OP_A2: begin
        h_nxt = mul_lo;
      end
      xxh32_pkg::OP_A3: begin
        hash_nxt    = h_r ^ (h_r >> 16);
        lane_nxt[0] = seed_r + xxh32_pkg::XP1 + xxh32_pkg::XP2;
        lane_nxt[1] = seed_r + xxh32_pkg::XP2;
        lane_nxt[2] = seed_r;
        lane_nxt[3] = seed_r - xxh32_pkg::XP1;
        fill_nxt    = '0;
        len_nxt     = '0;
        seen_nxt    = 1'b0;
      end
      default: begin
      end
    endcase

    // Seed write: re-derive lanes while no stripe has been folded
    if (cfg_valid) begin
      seed_nxt = cfg_data;
      if (!seen_r) begin
        lane_nxt[0] = cfg_data + xxh32_pkg::XP1 + xxh32_pkg::XP2;
        lane_nxt[1] = cfg_data + xxh32_pkg::XP2;
        lane_nxt[2] = cfg_data;
        lane_nxt[3] = cfg_data - xxh32_pkg::XP1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= '0;
      lane_r[0] <= xxh32_pkg::XP1 + xxh32_pkg::XP2;
      lane_r[1] <= xxh32_pkg::XP2;
      lane_r[2] <= '0;
      lane_r[3] <= 32'd0 - xxh32_pkg::XP1;
      fill_r    <= '0;
      len_r     <= '0;
      seen_r    <= 1'b0;
    end else begin
      seed_r <= seed_nxt;
      for (int i = 0; i < 4; i++) begin
        lane_r[i] <= lane_nxt[i];
      end
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    p_r    <= p_nxt;
    t_r    <= t_nxt;
    h_r    <= h_nxt;
    hash_r <= hash_nxt;
  end

  assign status.fill = fill_r;
  assign status.seen = seen_r;
  assign hash        = hash_r;

endmodule

@@ rtl/xxh32_ctrl.sv @@
module xxh32_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  xxh32_pkg::status_t  status,
  output xxh32_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_F_MUL,
    S_F_ROT,
    S_F_UPD,
    S_C_INIT,
    S_C_ADD,
    S_REM,
    S_W_MUL,
    S_W_ROT,
    S_W_UPD,
    S_B_MUL,
    S_B_ROT,
    S_B_UPD,
    S_A1,
    S_A2_A3
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  k_r, k_nxt;
  logic        last_r, last_nxt;
  logic        a3_r, a3_nxt;       // second avalanche step done, final xor pending
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;
  logic        fire_out;

  assign slot_free = !out_valid_r || out_tready;
  assign fire_out  = (state_r == S_A2_A3) && a3_r && slot_free;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.k  = k_r;
    cmd.op = xxh32_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE:   cmd.op = in_tvalid ? xxh32_pkg::OP_LOAD : xxh32_pkg::OP_NONE;
      S_F_MUL:  cmd.op = xxh32_pkg::OP_F_MUL;
      S_F_ROT:  cmd.op = xxh32_pkg::OP_F_ROT;
      S_F_UPD:  cmd.op = xxh32_pkg::OP_F_UPD;
      S_C_INIT: cmd.op = xxh32_pkg::OP_C_INIT;
      S_C_ADD:  cmd.op = xxh32_pkg::OP_C_ADD;
      S_W_MUL:  cmd.op = xxh32_pkg::OP_W_MUL;
      S_W_ROT:  cmd.op = xxh32_pkg::OP_W_ROT;
      S_W_UPD:  cmd.op = xxh32_pkg::OP_W_UPD;
      S_B_MUL:  cmd.op = xxh32_pkg::OP_B_MUL;
      S_B_ROT:  cmd.op = xxh32_pkg::OP_B_ROT;
      S_B_UPD:  cmd.op = xxh32_pkg::OP_B_UPD;
      S_A1:     cmd.op = xxh32_pkg::OP_A1;
      S_A2_A3: begin
        if (!a3_r) begin
          cmd.op = xxh32_pkg::OP_A2;
        end else if (slot_free) begin
          cmd.op = xxh32_pkg::OP_A3;
        end else begin
          cmd.op = xxh32_pkg::OP_NONE;
        end
      end
      default:  cmd.op = xxh32_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    a3_nxt        = a3_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          last_nxt  = in_tlast;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        k_nxt = 2'd0;
        priority if (status.fill >= xxh32_pkg::FILL_W'(16)) begin
          state_nxt = S_F_MUL;
        end else if (last_r) begin
          state_nxt = S_C_INIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_F_MUL: state_nxt = S_F_ROT;
      S_F_ROT: state_nxt = S_F_UPD;
      S_F_UPD: begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = last_r ? S_C_INIT : S_IDLE;
        end else begin
          state_nxt = S_F_MUL;
        end
      end
      S_C_INIT: begin
        k_nxt     = 2'd0;
        state_nxt = status.seen ? S_C_ADD : S_REM;
      end
      S_C_ADD: begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        priority if (status.fill >= xxh32_pkg::FILL_W'(4)) begin
          state_nxt = S_W_MUL;
        end else if (status.fill != '0) begin
          state_nxt = S_B_MUL;
        end else begin
          state_nxt = S_A1;
        end
      end
      S_W_MUL: state_nxt = S_W_ROT;
      S_W_ROT: state_nxt = S_W_UPD;
      S_W_UPD: state_nxt = S_REM;
      S_B_MUL: state_nxt = S_B_ROT;
      S_B_ROT: state_nxt = S_B_UPD;
      S_B_UPD: state_nxt = S_REM;
      S_A1: begin
        a3_nxt    = 1'b0;
        state_nxt = S_A2_A3;
      end
      S_A2_A3: begin
        if (!a3_r) begin
          a3_nxt = 1'b1;
        end else if (fire_out) begin
          out_valid_nxt = 1'b1;
          a3_nxt        = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 2'd0;
      last_r      <= 1'b0;
      a3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      last_r      <= last_nxt;
      a3_r        <= a3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ verif/xxhash32_checker.sv @@
`timescale 1ns / 1ps

// Watches the three channels of the hash core, keeps its own XXH32 state and
// checks every hash item against the oldest predicted value.
module xxhash32_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] data_word, [34:32] valid_bytes, rest zero
  input  logic        in_tlast,   // last item of the message
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] hash
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          hash_count,
  output int          byte_count
);

  localparam int REPORT_MAX = 10;

  logic [31:0]  seed_q;
  logic [31:0]  lane_q [4];
  logic [7:0]   stripe_q [16];
  int unsigned  fill_q;
  logic [31:0]  len_q;
  bit           folded_q;
  logic [31:0]  expected_hashes [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

  function automatic logic [31:0] word_at(input int unsigned pos);
    return {stripe_q[(pos + 3) & 15], stripe_q[(pos + 2) & 15],
            stripe_q[(pos + 1) & 15], stripe_q[pos & 15]};
  endfunction

  task automatic seed_lanes();
    lane_q[0] = seed_q + xxh32_pkg::XP1 + xxh32_pkg::XP2;
    lane_q[1] = seed_q + xxh32_pkg::XP2;
    lane_q[2] = seed_q;
    lane_q[3] = seed_q - xxh32_pkg::XP1;
  endtask

  task automatic clear_message();
    seed_lanes();
    fill_q   = 0;
    len_q    = '0;
    folded_q = 1'b0;
  endtask

  task automatic fold_stripe();
    logic [31:0] acc;
    for (int k = 0; k < 4; k++) begin
      acc       = lane_q[k] + mul_lo(word_at(4 * k), xxh32_pkg::XP2);
      lane_q[k] = mul_lo(rol(acc, 13), xxh32_pkg::XP1);
    end
    folded_q = 1'b1;
  endtask

  // Hash of the message so far: converge, add length, eat the tail, avalanche.
  function automatic logic [31:0] digest();
    logic [31:0] h;
    int unsigned pos;
    int unsigned rem;
    pos = 0;
    rem = fill_q;
    if (folded_q)
      h = rol(lane_q[0], 1) + rol(lane_q[1], 7) + rol(lane_q[2], 12) + rol(lane_q[3], 18);
    else
      h = seed_q + xxh32_pkg::XP5;
    h += len_q;
    while (rem >= 4) begin
      h += mul_lo(word_at(pos), xxh32_pkg::XP3);
      h = mul_lo(rol(h, 17), xxh32_pkg::XP4);
      pos += 4;
      rem -= 4;
    end
    while (rem > 0) begin
      h += mul_lo({24'd0, stripe_q[pos & 15]}, xxh32_pkg::XP5);
      h = mul_lo(rol(h, 11), xxh32_pkg::XP1);
      pos++;
      rem--;
    end
    h ^= h >> 15;
    h = mul_lo(h, xxh32_pkg::XP2);
    h ^= h >> 13;
    h = mul_lo(h, xxh32_pkg::XP3);
    h ^= h >> 16;
    return h;
  endfunction

  task automatic absorb(input logic [31:0] word, input logic [2:0] nb, input logic is_last);
    int unsigned n;
    n = (nb > 3'd4) ? 4 : nb;
    for (int unsigned i = 0; i < n; i++) begin
      stripe_q[fill_q] = word[8 * i +: 8];
      fill_q++;
      if (fill_q == 16) begin
        fold_stripe();
        fill_q = 0;
      end
    end
    len_q      += n;
    byte_count += n;
    if (is_last) begin
      expected_hashes.push_back(digest());
      clear_message();
    end
  endtask

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("[%0t] %s: expected %08h, got %08h", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_q = '0;
      clear_message();
      expected_hashes.delete();
    end else begin
      // Check the outgoing hash first so a same-edge push can never satisfy it.
      if (out_tvalid && out_tready) begin
        if (expected_hashes.size() == 0) begin
          report("hash item with none pending", 'x, out_tdata);
        end else begin
          if (out_tdata !== expected_hashes[0])
            report("hash mismatch", expected_hashes[0], out_tdata);
          void'(expected_hashes.pop_front());
          hash_count++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        seed_q = cfg_data;
        if (!folded_q)
          seed_lanes();
      end
      if (in_tvalid && in_tready)
        absorb(in_tdata[31:0], in_tdata[34:32], in_tlast);
    end
    pending = expected_hashes.size();
  end

endmodule

@@ verif/xxhash32_stream_core_test.sv @@
`timescale 1ns / 1ps

module xxhash32_stream_core_test;

  localparam int PHASES       = 11;     // seed settings over the run
  localparam int PHASE_ITEMS  = 60;     // random items per phase
  localparam int DRAIN_CYCLES = 80;     // covers the longest item plus finish
  localparam int CYCLE_LIMIT  = 500000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [31:0] data_word, [34:32] valid_bytes, rest zero
  logic        in_tlast;   // last item of the message
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] hash
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  int fail_count;
  int pending;
  int hash_count;
  int byte_count;

  int cycle_count = 0;
  int burst_left  = 0;
  int seed_writes = 0;
  bit msg_open    = 1'b0;
  int items_left  = 0;

  int          stall_mode = 0;
  int          stall_left = 0;
  logic [15:0] stall_mask = '1;

  xxhash32_stream_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  xxhash32_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .hash_count (hash_count),
    .byte_count (byte_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run; a hang or a lost hash ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: switch between stall styles at random intervals.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 300);
        stall_mask = $urandom;
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: begin
          out_tready = 1'b1;
        end
        1: begin
          out_tready = ($urandom_range(0, 9) < 7);
        end
        2: begin
          out_tready = stall_mask[0];
          stall_mask = {stall_mask[0], stall_mask[15:1]};
        end
        default: begin
          out_tready = ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Offer one item; hold valid across a burst, drop it for a random gap.
  task automatic push_item(input logic [31:0] word, input logic [2:0] nb, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_tdata  = {5'd0, nb, word};
    in_tlast  = is_last;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Next item of a random message; messages may straddle a seed write.
  task automatic push_random_item();
    int          pick;
    logic [2:0]  nb;
    if (!msg_open) begin
      pick       = $urandom_range(0, 9);
      items_left = (pick < 5) ? $urandom_range(1, 6) :
                   (pick < 9) ? $urandom_range(7, 20) : $urandom_range(21, 48);
      msg_open   = 1'b1;
    end
    pick = $urandom_range(0, 15);
    nb   = (pick < 10) ? 3'd4 :
           (pick < 13) ? 3'($urandom_range(1, 3)) :
           (pick == 13) ? 3'd0 : 3'($urandom_range(5, 7));
    items_left--;
    if (items_left == 0)
      msg_open = 1'b0;
    push_item($urandom, nb, items_left == 0);
  endtask

  // Let the core go idle: no hash outstanding, last item fully worked off.
  task automatic quiesce();
    in_tvalid  = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    seed_writes++;
  endtask

  initial begin
    logic [31:0] seed_pick;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    write_seed(32'h0000_0000);
    // Empty message, then a lone byte with junk in the upper bytes.
    push_item(32'h0000_0000, 3'd0, 1'b1);
    push_item(32'hDEAD_BEFF, 3'd1, 1'b1);
    // Byte counts above four act as four.
    push_item(32'hFFFF_FFFF, 3'd7, 1'b1);
    push_item(32'hA5A5_A5A5, 3'd5, 1'b0);
    push_item(32'h1234_5678, 3'd0, 1'b1);
    // Stripe that completes exactly on the last item.
    push_item(32'h0000_0000, 3'd4, 1'b0);
    push_item(32'hFFFF_FFFF, 3'd4, 1'b0);
    push_item(32'h8000_0001, 3'd4, 1'b0);
    push_item(32'h7FFF_FFFE, 3'd4, 1'b1);
    // One stripe plus the longest tail: three words and three bytes.
    for (int i = 0; i < 7; i++)
      push_item($urandom, 3'd4, 1'b0);
    push_item($urandom, 3'd3, 1'b1);
    push_item(32'h0000_0000, 3'd4, 1'b0);
    push_item(32'hFFFF_FFFF, 3'd4, 1'b1);
    // Leave a message open with no stripe folded yet.
    push_item($urandom, 3'd4, 1'b0);
    push_item($urandom, 3'd4, 1'b0);
    msg_open   = 1'b1;
    items_left = $urandom_range(1, 10);

    // New seed mid-message before any fold: lanes restart from it.
    quiesce();
    write_seed(32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++)
      push_item($urandom, 3'd4, 1'b0);

    // Remaining phases; the first one writes the seed after a fold.
    for (int ph = 2; ph < PHASES; ph++) begin
      quiesce();
      case (ph)
        2:       seed_pick = 32'h8000_0000;
        3:       seed_pick = 32'h0000_0000;
        4:       seed_pick = 32'hFFFF_FFFF;
        default: seed_pick = $urandom;
      endcase
      write_seed(seed_pick);
      for (int n = 0; n < PHASE_ITEMS || (ph == PHASES - 1 && msg_open); n++)
        push_random_item();
    end

    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d hashes over %0d message bytes with %0d seed writes",
             hash_count, byte_count, seed_writes);
    $display("Covered empty, short, oversized-count, exact-stripe and mid-message seed cases");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
